>>> sv/mtne_pkg.sv
package mtne_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int BYTE_W      = 8;
   localparam int IDX_W       = $clog2(MAX_PATTERN);
   localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
   localparam int LEN_W       = 5;
   localparam int VALUE_W     = 63;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int MARKER_W    = 2 * CSR_DATA_W;

   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   localparam logic STATUS_FOUND     = 1'b0;
   localparam logic STATUS_NOT_FOUND = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PATTERN_LENGTH = 2'd0,
      REG_PATTERN_LOW    = 2'd1,
      REG_PATTERN_HIGH   = 2'd2
   } csr_reg_type;

   // marker byte 0 sits in bits 7:0
   typedef struct packed {
      logic [LEN_W-1:0]    pattern_length;
      logic [MARKER_W-1:0] marker;
   } cfg_type;

endpackage

>>> sv/mtne_ifs.sv
interface mtne_req_if;
   import mtne_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mtne_rsp_if;
   import mtne_pkg::*;
   logic               valid;
   logic               ready;
   logic               status;
   logic [VALUE_W-1:0] value;
   logic               overflowed;
   modport source (output valid, output status, output value, output overflowed,
                   input ready);
   modport sink (input valid, input status, input value, input overflowed,
                 output ready);
endinterface

interface mtne_csr_if;
   import mtne_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/mtne_csr.sv
module mtne_csr (
   input  logic              clock,
   input  logic              reset,
   mtne_csr_if.sink          csr_ch,
   output mtne_pkg::cfg_type cfg
);
   import mtne_pkg::*;

   logic [LEN_W-1:0]      length_ff, length_in;
   logic [CSR_DATA_W-1:0] low_ff, low_in;
   logic [CSR_DATA_W-1:0] high_ff, high_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      length_in = length_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      if (csr_ch.valid) begin
         case (csr_reg_type'(csr_ch.index))
            REG_PATTERN_LENGTH: length_in = csr_ch.data[LEN_W-1:0];
            REG_PATTERN_LOW:    low_in    = csr_ch.data;
            REG_PATTERN_HIGH:   high_in   = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LEN_W'(1);
         low_ff    <= '0;
         high_ff   <= '0;
      end else begin
         length_ff <= length_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
      end
   end

   assign cfg.pattern_length = length_ff;
   assign cfg.marker         = {high_ff, low_ff};

endmodule

>>> sv/mtne_core.sv
module mtne_core (
   input logic              clock,
   input logic              reset,
   input mtne_pkg::cfg_type cfg,
   mtne_req_if.sink         req_ch,
   mtne_rsp_if.source       rsp_ch
);
   import mtne_pkg::*;

   localparam int WIDE_W = VALUE_W + 4;

   typedef enum logic [1:0] {
      PH_SEARCH,
      PH_PARSE,
      PH_DONE
   } phase_type;

   logic              item_valid_ff, item_valid_in;
   logic [BYTE_W-1:0] item_byte_ff, item_byte_in;
   logic              item_last_ff, item_last_in;
   logic              advance;

   phase_type          phase_ff, phase_in;
   logic [BYTE_W-1:0]  window_ff [MAX_PATTERN];
   logic [BYTE_W-1:0]  window_sh [MAX_PATTERN];
   logic [CNT_W-1:0]   seen_ff, seen_in, seen_sh;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               ovf_ff, ovf_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic [CNT_W-1:0]       used_len;
   logic [CNT_W-1:0]       tap_idx [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] hit;
   logic                   match;
   logic                   is_digit, is_skip;
   logic [BYTE_W-1:0]      digit;
   logic [WIDE_W-1:0]      wide_sum;
   logic                   acc_ovf;
   logic [VALUE_W-1:0]     acc_step;
   logic                   ovf_step;

   logic               emit;
   logic               emit_status;
   logic [VALUE_W-1:0] emit_value;
   logic               emit_ovf;

   // handshake: the item register drains whenever the result register can take a result
   assign advance      = item_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !item_valid_ff || advance;

   always_comb begin
      item_valid_in = item_valid_ff;
      item_byte_in  = item_byte_ff;
      item_last_in  = item_last_ff;
      if (req_ch.valid && req_ch.ready) begin
         item_valid_in = 1'b1;
         item_byte_in  = req_ch.data_byte;
         item_last_in  = req_ch.last_byte;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   // clamp length to 1..MAX_PATTERN
   always_comb begin
      if (cfg.pattern_length == '0) begin
         used_len = CNT_W'(1);
      end else if (CNT_W'(cfg.pattern_length) > CNT_W'(MAX_PATTERN)) begin
         used_len = CNT_W'(MAX_PATTERN);
      end else begin
         used_len = CNT_W'(cfg.pattern_length);
      end
   end

   // window with the current byte shifted in, entry 0 newest
   always_comb begin
      window_sh[0] = item_byte_ff;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         window_sh[i] = window_ff[i-1];
      end
   end

   assign seen_sh = (seen_ff < CNT_W'(MAX_PATTERN)) ? seen_ff + CNT_W'(1) : seen_ff;

   // marker byte j lines up with window entry used_len-1-j
   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         tap_idx[j] = used_len - CNT_W'(1) - CNT_W'(j);
         hit[j]     = (CNT_W'(j) >= used_len) ||
                      (window_sh[tap_idx[j][IDX_W-1:0]] == cfg.marker[j*BYTE_W +: BYTE_W]);
      end
   end

   assign match = (seen_sh >= used_len) && (&hit);

   assign is_digit = (item_byte_ff >= CHAR_ZERO) && (item_byte_ff <= CHAR_NINE);
   assign is_skip  = (item_byte_ff == CHAR_SPACE) || (item_byte_ff == CHAR_COMMA);
   assign digit    = item_byte_ff - CHAR_ZERO;

   // acc * 10 + digit as (acc << 3) + (acc << 1) + digit, wide enough to see overflow
   assign wide_sum = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + WIDE_W'(digit);
   assign acc_ovf  = |wide_sum[WIDE_W-1:VALUE_W];
   assign acc_step = acc_ovf ? VALUE_MAX : wide_sum[VALUE_W-1:0];
   assign ovf_step = ovf_ff | acc_ovf;

   always_comb begin
      phase_in    = phase_ff;
      seen_in     = seen_ff;
      acc_in      = acc_ff;
      ovf_in      = ovf_ff;
      emit        = 1'b0;
      emit_status = STATUS_FOUND;
      emit_value  = acc_ff;
      emit_ovf    = ovf_ff;
      if (advance) begin
         case (phase_ff)
            PH_SEARCH: begin
               seen_in = seen_sh;
               if (match) begin
                  phase_in   = PH_PARSE;
                  acc_in     = '0;
                  ovf_in     = 1'b0;
                  emit       = item_last_ff;
                  emit_value = '0;
                  emit_ovf   = 1'b0;
               end else begin
                  emit        = item_last_ff;
                  emit_status = STATUS_NOT_FOUND;
                  emit_value  = '0;
                  emit_ovf    = 1'b0;
               end
            end
            PH_PARSE: begin
               if (is_digit) begin
                  acc_in     = acc_step;
                  ovf_in     = ovf_step;
                  emit       = item_last_ff;
                  emit_value = acc_step;
                  emit_ovf   = ovf_step;
               end else if (is_skip) begin
                  emit = item_last_ff;
               end else begin
                  emit     = 1'b1;
                  phase_in = PH_DONE;
               end
            end
            default: ;
         endcase
         if (item_last_ff) begin
            phase_in = PH_SEARCH;
            seen_in  = '0;
            acc_in   = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      if (advance && emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_status;
         rsp_value_in  = emit_value;
         rsp_ovf_in    = emit_ovf;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         phase_ff      <= PH_SEARCH;
         seen_ff       <= '0;
         acc_ff        <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         phase_ff      <= phase_in;
         seen_ff       <= seen_in;
         acc_ff        <= acc_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_byte_ff  <= item_byte_in;
      item_last_ff  <= item_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      if (advance && phase_ff == PH_SEARCH) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            window_ff[i] <= window_sh[i];
         end
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.value      = rsp_value_ff;
   assign rsp_ch.overflowed = rsp_ovf_ff;

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      advance && item_last_ff |=> phase_ff == PH_SEARCH && seen_ff == '0)
      else $error("document state not cleared after last byte");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CNT_W'(MAX_PATTERN))
      else $error("byte count beyond marker depth");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_NOT_FOUND |-> rsp_value_ff == '0 && !rsp_ovf_ff)
      else $error("not-found result carries a value");

   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |-> rsp_value_ff == VALUE_MAX)
      else $error("overflow flagged without saturation");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> rsp_valid_ff && $stable(rsp_value_ff))
      else $error("pending result lost");

endmodule

>>> sv/marker_then_number_extractor.sv
// path: an accepted byte is held in the item register, and any result it gives is then loaded
//   into the result register; a result the receiver holds back stalls the item register
// throughput: one byte per cycle without such a stall, limited by the single item register
// reset: synchronous, active high; clears handshake and document state, marker length to 1 and
//   marker bytes to zero; no clearing pass, bytes are accepted from the first cycle after reset
module marker_then_number_extractor (
   input logic        clock,
   input logic        reset,
   mtne_req_if.sink   req_ch,
   mtne_rsp_if.source rsp_ch,
   mtne_csr_if.sink   csr_ch
);
   import mtne_pkg::*;

   // live marker configuration; the user must write it between documents, the block does not enforce this
   cfg_type cfg;

   // register file: length, low marker word, high marker word
   mtne_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // byte pipeline: item register, window match and decimal parse, result register
   // each request transaction either updates document state only or also loads a result
   mtne_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

>>> sim/extraction_checker.sv
`timescale 1ns / 100ps

module extraction_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [mtne_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic                             req_last_byte,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             rsp_status,
   input  logic [mtne_pkg::VALUE_W-1:0]     rsp_value,
   input  logic                             rsp_overflowed,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [mtne_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mtne_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               fail_count,
   output int                               pending_count,
   output int                               found_count,
   output int                               missing_count,
   output int                               saturated_count
);
   import mtne_pkg::*;

   typedef enum logic [1:0] {
      SCANNING,
      PARSING,
      FINISHED
   } doc_phase_type;

   typedef struct packed {
      logic               status;
      logic [VALUE_W-1:0] value;
      logic               overflowed;
   } extract_result_type;

   // shadow copy of the marker registers
   logic [LEN_W-1:0]    pattern_length;
   logic [MARKER_W-1:0] marker;

   // document state
   logic [BYTE_W-1:0]   window [MAX_PATTERN];
   int unsigned         seen;
   doc_phase_type       doc_phase;
   logic [VALUE_W-1:0]  number;
   logic                number_ovf;

   extract_result_type  expected_results [$];
   int                  fails     = 0;
   int                  found     = 0;
   int                  missing   = 0;
   int                  saturated = 0;

   task automatic clear_document();
      for (int i = 0; i < MAX_PATTERN; i++) window[i] = '0;
      seen       = 0;
      doc_phase  = SCANNING;
      number     = '0;
      number_ovf = 1'b0;
   endtask

   function automatic bit marker_seen();
      int n;
      n = int'(pattern_length);
      if (n == 0) n = 1;
      if (n > MAX_PATTERN) n = MAX_PATTERN;
      if (seen < n) return 1'b0;
      for (int j = 0; j < n; j++) begin
         if (window[n-1-j] != marker[j*BYTE_W +: BYTE_W]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic push_result(input logic status, input logic [VALUE_W-1:0] value,
                              input logic ovf);
      extract_result_type r;
      r.status     = status;
      r.value      = value;
      r.overflowed = ovf;
      expected_results.push_back(r);
   endtask

   // saturate at the top of the 63-bit range
   task automatic add_digit(input logic [3:0] d);
      logic [63:0] acc;
      logic [63:0] bound;
      acc   = {1'b0, number};
      bound = ({1'b0, VALUE_MAX} - 64'(d)) / 64'd10;
      if (acc > bound) begin
         number     = VALUE_MAX;
         number_ovf = 1'b1;
      end else begin
         number = VALUE_W'(acc * 64'd10 + 64'(d));
      end
   endtask

   task automatic predict_extraction(input logic [BYTE_W-1:0] b, input logic last);
      case (doc_phase)
         SCANNING: begin
            for (int i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = b;
            if (seen < MAX_PATTERN) seen++;
            if (marker_seen()) begin
               doc_phase  = PARSING;
               number     = '0;
               number_ovf = 1'b0;
               if (last) push_result(STATUS_FOUND, '0, 1'b0);
            end else if (last) begin
               push_result(STATUS_NOT_FOUND, '0, 1'b0);
            end
         end
         PARSING: begin
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               add_digit(4'(b - CHAR_ZERO));
               if (last) push_result(STATUS_FOUND, number, number_ovf);
            end else if (b == CHAR_SPACE || b == CHAR_COMMA) begin
               if (last) push_result(STATUS_FOUND, number, number_ovf);
            end else begin
               push_result(STATUS_FOUND, number, number_ovf);
               doc_phase = FINISHED;
            end
         end
         default: ;
      endcase
      if (last) clear_document();
   endtask

   always @(posedge clock) begin : monitor
      extract_result_type got;
      extract_result_type want;
      if (reset) begin
         pattern_length = LEN_W'(1);
         marker         = '0;
         clear_document();
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PATTERN_LENGTH: pattern_length = csr_data[LEN_W-1:0];
               REG_PATTERN_LOW:    marker[CSR_DATA_W-1:0] = csr_data;
               REG_PATTERN_HIGH:   marker[MARKER_W-1:CSR_DATA_W] = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_extraction(req_data_byte, req_last_byte);
         if (rsp_valid && rsp_ready) begin
            got.status     = rsp_status;
            got.value      = rsp_value;
            got.overflowed = rsp_overflowed;
            if (expected_results.size() == 0) begin
               $error("result with none expected: status %0d value %0d overflowed %0d",
                      got.status, got.value, got.overflowed);
               fails++;
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                  fails++;
               end
               if (got.value !== want.value) begin
                  $error("value mismatch: expected %0d, actual %0d", want.value, got.value);
                  fails++;
               end
               if (got.overflowed !== want.overflowed) begin
                  $error("overflowed mismatch: expected %0d, actual %0d",
                         want.overflowed, got.overflowed);
                  fails++;
               end
               if (want.status == STATUS_FOUND) found++;
               else missing++;
               if (want.overflowed) saturated++;
            end
         end
      end
      fail_count      <= fails;
      pending_count   <= expected_results.size();
      found_count     <= found;
      missing_count   <= missing;
      saturated_count <= saturated;
   end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import mtne_pkg::*;

   // index with no register behind it, writes must be ignored
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int IDLE_LIMIT   = 5000;  // cycles with no transaction before giving up
   localparam int PHASE_ITEMS  = 125;   // minimum bytes per marker setting
   localparam int PHASES       = 8;
   localparam int DRAIN_CYCLES = 10;    // margin for bytes still in the block

   logic clock = 1'b0;
   logic reset;

   always #5 clock = ~clock;

   mtne_req_if req_ch ();
   mtne_rsp_if rsp_ch ();
   mtne_csr_if csr_ch ();

   marker_then_number_extractor uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   int fail_count;
   int pending_count;
   int found_count;
   int missing_count;
   int saturated_count;

   extraction_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_data_byte   (req_ch.data_byte),
      .req_last_byte   (req_ch.last_byte),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_value       (rsp_ch.value),
      .rsp_overflowed  (rsp_ch.overflowed),
      .csr_valid       (csr_ch.valid),
      .csr_ready       (csr_ch.ready),
      .csr_index       (csr_ch.index),
      .csr_data        (csr_ch.data),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .found_count     (found_count),
      .missing_count   (missing_count),
      .saturated_count (saturated_count)
   );

   // sender pacing
   bit gaps_on = 1'b1;
   int burst_left = 0;

   // set by the stimulus to ask the receiver for one long hold-off
   bit hold_request = 1'b0;

   int items_sent = 0;
   int docs_sent = 0;
   int settings_used = 0;

   // current marker as the block will use it
   logic [BYTE_W-1:0] marker_bytes [MAX_PATTERN];
   int marker_len = 1;

   // a marker split across two documents
   bit cut_pending = 1'b0;
   int cut_at = 0;

   logic [BYTE_W-1:0] doc_bytes [$];

   // ---------------------------------------------------------------
   // receiver: ready follows a pattern of its own, mode changes now and then
   // ---------------------------------------------------------------
   initial begin
      int mode;
      int mode_left;
      int tick;
      mode = 0;
      mode_left = 0;
      tick = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_request) begin
            // long hold-off so the block backs up and stalls its input
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(32, 200);
         end
         mode_left--;
         case (mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= ((tick % 8) < 5);
         endcase
      end
   end

   // ---------------------------------------------------------------
   // watchdog: too long without any transaction ends the run
   // ---------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d cycles without a transaction", idle_cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // byte and document sending
   // ---------------------------------------------------------------

   // one byte; bursts of random length, random gaps between them while gaps are on
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on) begin
            gap = $urandom_range(1, 6);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= last;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic send_document();
      for (int i = 0; i < doc_bytes.size(); i++) begin
         send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
      end
      docs_sent++;
   endtask

   // stop sending and wait until every expected result has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      // trailing bytes after a terminator give no result, let them pass
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // raises valid only; the caller lowers it after the last write
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // writes all registers plus an ignored index, and mirrors the marker locally
   task automatic configure(input logic [LEN_W-1:0] len, input logic [CSR_DATA_W-1:0] low,
                            input logic [CSR_DATA_W-1:0] high);
      logic [CSR_DATA_W-1:0] len_word;
      len_word = random_word();
      len_word[LEN_W-1:0] = len;
      csr_write(REG_PATTERN_LOW, low);
      csr_write(REG_UNUSED, random_word());
      csr_write(REG_PATTERN_LENGTH, len_word);
      csr_write(REG_PATTERN_HIGH, high);
      csr_ch.valid <= 1'b0;
      // zero acts as one, above the maximum acts as the maximum
      marker_len = int'(len);
      if (marker_len == 0) marker_len = 1;
      if (marker_len > MAX_PATTERN) marker_len = MAX_PATTERN;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         marker_bytes[k] = (k < 8) ? low[k*BYTE_W +: BYTE_W] : high[(k-8)*BYTE_W +: BYTE_W];
      end
      settings_used++;
   endtask

   // ---------------------------------------------------------------
   // document building
   // ---------------------------------------------------------------
   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
   endtask

   // random bytes, half of them taken from the marker for partial matches
   task automatic append_prefix();
      int n;
      n = $urandom_range(0, 6);
      repeat (n) begin
         if ($urandom_range(0, 1)) doc_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
         else doc_bytes.push_back(marker_bytes[$urandom_range(0, marker_len - 1)]);
      end
   endtask

   task automatic append_separators();
      int n;
      n = $urandom_range(1, 2);
      repeat (n) doc_bytes.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_COMMA);
   endtask

   // digits with separators sprinkled in; sometimes long enough to saturate
   task automatic append_number();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) append_separators();
      if (r < 4) begin
         append_text("9223372036854775807");
      end else if (r < 8) begin
         append_text("9223372036854775808");
      end else begin
         n = (r < 14) ? $urandom_range(18, 24) : $urandom_range(0, 6);
         repeat (n) begin
            if ($urandom_range(0, 3) == 0) append_separators();
            doc_bytes.push_back(CHAR_ZERO + BYTE_W'($urandom_range(0, 9)));
         end
      end
      if ($urandom_range(0, 3) == 0) append_separators();
   endtask

   task automatic build_document();
      int r;
      bit open_tail;
      logic [BYTE_W-1:0] b;
      doc_bytes.delete();
      open_tail = 1'b1;
      if (cut_pending) begin
         // rest of a marker whose head ended the previous document
         cut_pending = 1'b0;
         for (int k = cut_at; k < marker_len; k++) doc_bytes.push_back(marker_bytes[k]);
         append_number();
      end else begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            // well formed: prefix, marker, number
            append_prefix();
            for (int k = 0; k < marker_len; k++) doc_bytes.push_back(marker_bytes[k]);
            append_number();
         end else if (r < 88) begin
            // noise
            repeat ($urandom_range(1, 12)) doc_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
         end else begin
            // document ends inside the marker
            append_prefix();
            if (marker_len > 1) begin
               cut_at = $urandom_range(1, marker_len - 1);
               for (int k = 0; k < cut_at; k++) doc_bytes.push_back(marker_bytes[k]);
               cut_pending = 1'b1;
            end
            open_tail = 1'b0;
         end
      end
      if (open_tail && $urandom_range(0, 1)) begin
         // terminating byte, then bytes the block must ignore
         do b = BYTE_W'($urandom_range(0, 255));
         while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_SPACE || b == CHAR_COMMA);
         doc_bytes.push_back(b);
         repeat ($urandom_range(0, 3)) doc_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      end
      if (doc_bytes.size() == 0) doc_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
   endtask

   // ---------------------------------------------------------------
   // main stimulus
   // ---------------------------------------------------------------
   initial begin
      int phase_start;
      logic [LEN_W-1:0] len;
      logic [CSR_DATA_W-1:0] low;
      logic [CSR_DATA_W-1:0] high;

      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.last_byte <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= REG_PATTERN_LENGTH;
      csr_ch.data      <= '0;
      for (int k = 0; k < MAX_PATTERN; k++) marker_bytes[k] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed documents on the reset marker: one zero byte
      // marker on the final byte
      doc_bytes = '{8'h00};
      send_document();
      // marker absent
      doc_bytes = '{8'hFF};
      send_document();
      // separators skipped, terminator ends the number, later bytes ignored
      doc_bytes = '{8'h00, "1", ",", " ", "2", "x", "5"};
      send_document();
      // one past the largest value: saturates, document ends on a digit
      doc_bytes.delete();
      doc_bytes.push_back(8'h00);
      append_text("9223372036854775808");
      send_document();
      drain();

      // random documents over a range of marker settings
      for (int p = 0; p < PHASES; p++) begin
         low  = random_word();
         high = random_word();
         case (p)
            0: len = LEN_W'(MAX_PATTERN);
            1: len = LEN_W'(1);
            2: begin
               len  = '0;        // acts as one
               low  = '1;
               high = '0;
            end
            3: begin
               len  = '1;        // above the maximum
               high = '1;
            end
            4: len = LEN_W'($urandom_range(2, MAX_PATTERN - 1));
            5: len = LEN_W'($urandom_range(MAX_PATTERN + 1, 30));
            6: len = LEN_W'(3);
            default: begin
               len  = LEN_W'(MAX_PATTERN);
               low  = '0;
               high = '0;
            end
         endcase
         configure(len, low, high);
         cut_pending = 1'b0;
         gaps_on = (p % 3 != 1);   // some settings run without sender gaps
         if (p == 2) hold_request = 1'b1;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            build_document();
            send_document();
         end
         drain();
      end

      $display("sent %0d bytes in %0d documents over %0d marker settings, with one long hold",
               items_sent, docs_sent, settings_used);
      $display("results checked: %0d found, %0d not found, %0d saturated",
               found_count, missing_count, saturated_count);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
